// ----- src/rse_pkg.sv -----
// Shared types and constants for the roll spread estimator.
// Used by rse_math and roll_spread_estimator; no dependencies.
package rse_pkg;

  localparam int MAX_WINDOW_DEF = 256;
  localparam int PRICE_BITS_DEF = 24;
  localparam int SPREAD_BITS    = 41;
  localparam int FRAC_SHIFT     = 34;
  localparam int BARS_BITS      = 9;

  localparam logic [7:0]           WINDOW_RESET = 8'd60;
  localparam logic [BARS_BITS-1:0] BARS_MAX     = 9'd511;
  localparam logic [BARS_BITS-1:0] BARS_MIN_OUT = 9'd3;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SWEEP,
    T_MATH,
    T_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MULN,
    M_MULS,
    M_CHECK,
    M_DIV,
    M_SQRT,
    M_DONE
  } math_state_t;

endpackage

// ----- src/rse_math.sv -----
// Covariance-to-spread arithmetic: serial multiplies, restoring divide, bitwise root.
// Depends on rse_pkg.
module rse_math #(
  parameter int NW  = 9,
  parameter int SW  = 34,
  parameter int PSW = 59
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [NW-1:0]                    n,
  input  logic signed [SW-1:0]             s1,
  input  logic signed [SW-1:0]             s2,
  input  logic signed [PSW-1:0]            p,
  output logic                             done,
  output logic [rse_pkg::SPREAD_BITS-1:0]  spread
);

  localparam int NUMW = 2 * SW + 1;
  localparam int XRAW = NUMW + rse_pkg::FRAC_SHIFT;
  localparam int XW   = XRAW + (XRAW % 2);
  localparam int QW   = XW / 2;
  localparam int RW   = QW + 2;
  localparam int DVW  = 2 * NW;
  localparam int CTW  = $clog2(XW + 1);

  rse_pkg::math_state_t state, state_next;

  logic signed [NUMW-1:0] acc;
  logic signed [NUMW-1:0] mcand;
  logic [SW-1:0]          mplier;
  logic [CTW-1:0]         cnt;
  logic [XW-1:0]          x;
  logic [DVW-1:0]         dvsr;
  logic [DVW:0]           drem;
  logic [RW-1:0]          srem;
  logic [QW-1:0]          root;

  logic [DVW:0]           drem_sh;
  logic [RW-1:0]          srem_sh;
  logic [RW-1:0]          trial;
  logic signed [NUMW-1:0] neg_acc;

  assign drem_sh = {drem[DVW-1:0], x[XW-1]};
  assign srem_sh = {srem[RW-3:0], x[XW-1:XW-2]};
  assign trial   = RW'({root, 2'b01});
  assign neg_acc = -acc;
  assign done    = (state == rse_pkg::M_DONE);

  // saturate the root to the output width; root is cleared when no root is taken
  assign spread  = ((root >> rse_pkg::SPREAD_BITS) != '0) ? '1 :
                   rse_pkg::SPREAD_BITS'(root);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rse_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rse_pkg::M_IDLE: begin
        if (start) state_next = rse_pkg::M_MULN;
      end
      rse_pkg::M_MULN: begin
        if (cnt == CTW'(NW - 1)) state_next = rse_pkg::M_MULS;
      end
      rse_pkg::M_MULS: begin
        if (cnt == CTW'(SW - 1)) state_next = rse_pkg::M_CHECK;
      end
      rse_pkg::M_CHECK: begin
        if (n < NW'(2) || !acc[NUMW-1]) state_next = rse_pkg::M_DONE;
        else state_next = rse_pkg::M_DIV;
      end
      rse_pkg::M_DIV: begin
        if (cnt == CTW'(XW - 1)) state_next = rse_pkg::M_SQRT;
      end
      rse_pkg::M_SQRT: begin
        if (cnt == CTW'(QW - 1)) state_next = rse_pkg::M_DONE;
      end
      rse_pkg::M_DONE: state_next = rse_pkg::M_IDLE;
      default: state_next = rse_pkg::M_IDLE;
    endcase
  end

  // datapath: one add, subtract or compare per cycle
  always_ff @(posedge clk) begin
    case (state)
      rse_pkg::M_IDLE: begin
        acc    <= '0;
        mcand  <= NUMW'(p);
        mplier <= SW'(n);
        cnt    <= '0;
      end
      rse_pkg::M_MULN: begin
        if (mplier[0]) acc <= acc + mcand;
        if (cnt == CTW'(NW - 1)) begin
          // n*P done; load -S1*S2 as S1 (or -S1) times |S2|
          mcand  <= s2[SW-1] ? NUMW'(s1) : -NUMW'(s1);
          mplier <= s2[SW-1] ? SW'(-s2) : SW'(s2);
          cnt    <= '0;
        end else begin
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + CTW'(1);
        end
      end
      rse_pkg::M_MULS: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CTW'(1);
      end
      rse_pkg::M_CHECK: begin
        x      <= XW'({neg_acc, {rse_pkg::FRAC_SHIFT{1'b0}}});
        dvsr   <= DVW'(n) * DVW'(n - NW'(1));
        drem   <= '0;
        srem   <= '0;
        root   <= '0;
        cnt    <= '0;
      end
      rse_pkg::M_DIV: begin
        // shift quotient bits into the low end of x
        if (drem_sh >= {1'b0, dvsr}) begin
          drem <= drem_sh - {1'b0, dvsr};
          x    <= {x[XW-2:0], 1'b1};
        end else begin
          drem <= drem_sh;
          x    <= {x[XW-2:0], 1'b0};
        end
        if (cnt == CTW'(XW - 1)) cnt <= '0;
        else cnt <= cnt + CTW'(1);
      end
      rse_pkg::M_SQRT: begin
        x <= {x[XW-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem <= srem_sh - trial;
          root <= {root[QW-2:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[QW-2:0], 1'b0};
        end
        cnt <= cnt + CTW'(1);
      end
      rse_pkg::M_DONE: begin
        cnt <= '0;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

// ----- src/roll_spread_estimator.sv -----
// The first two closes go straight to the output; otherwise the block sweeps the
// change history (one memory read per cycle), runs two serial multiplies, then the
// divide and the square root (both skipped when the covariance is not negative or
// n < 2). One close is taken at a time; the next is taken once the result sits in
// the output register. Synchronous reset clears control and counts; sums clear on each
// accepted close and the history memory needs no clearing. Depends on rse_pkg and rse_math.
module roll_spread_estimator #(
  parameter int MAX_WINDOW = rse_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rse_pkg::PRICE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             close_valid,
  output logic                             close_stall,
  input  logic [PRICE_BITS-1:0]            close_price,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             valid_res,
  output logic [rse_pkg::SPREAD_BITS-1:0]  spread
);

  localparam int DEPTH = MAX_WINDOW + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = PRICE_BITS + 1;
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = DW + NW;
  localparam int PSW   = 2 * DW + NW;
  localparam int BW    = rse_pkg::BARS_BITS;

  rse_pkg::top_state_t state, state_next;

  logic [7:0]                window;
  logic [PRICE_BITS-1:0]     prev_close;
  logic [BW-1:0]             bars_seen;
  logic [AW-1:0]             wp;
  logic [AW-1:0]             raddr;
  logic signed [DW-1:0]      mem [DEPTH];
  logic signed [DW-1:0]      rdata;
  logic                      rd_v;
  logic [NW:0]               rd_k;
  logic [NW:0]               iss;
  logic [NW-1:0]             n_reg;
  logic signed [DW-1:0]      prevd;
  logic signed [SW-1:0]      s1;
  logic signed [SW-1:0]      s2;
  logic signed [PSW-1:0]     p;
  logic                      math_start;
  logic                      pend_valid;
  logic [rse_pkg::SPREAD_BITS-1:0] pend_spread;

  logic                      accept;
  logic                      out_free;
  logic [BW-1:0]             bars_next;
  logic [AW-1:0]             wp_next;
  logic signed [DW-1:0]      change;
  logic [9:0]                lim_w;
  logic [9:0]                lim_b;
  logic [9:0]                n_lim;
  logic [NW-1:0]             n_new;
  logic signed [2*DW-1:0]    prod;
  logic                      math_done;
  logic [rse_pkg::SPREAD_BITS-1:0] math_spread;

  assign close_stall = (state != rse_pkg::T_IDLE);
  assign accept      = close_valid && !close_stall;
  assign out_free    = !res_valid || !res_stall;
  assign bars_next   = (bars_seen == rse_pkg::BARS_MAX) ? bars_seen : bars_seen + BW'(1);
  assign wp_next     = (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
  assign change      = $signed({1'b0, close_price}) - $signed({1'b0, prev_close});
  assign prod        = prevd * rdata;

  // pair count: min(window+1, closes-2, MAX_WINDOW)
  always_comb begin
    lim_w = {2'b00, window} + 10'd1;
    lim_b = {1'b0, bars_next} - 10'd2;
    n_lim = (lim_w < lim_b) ? lim_w : lim_b;
    if (int'(n_lim) > MAX_WINDOW) n_new = NW'(MAX_WINDOW);
    else n_new = NW'(n_lim);
  end

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= rse_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  // change history: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && bars_seen != '0) mem[wp_next] <= change;
    rdata <= mem[raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rse_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rse_pkg::T_IDLE: begin
        if (accept) begin
          if (bars_next < rse_pkg::BARS_MIN_OUT) state_next = rse_pkg::T_EMIT;
          else state_next = rse_pkg::T_SWEEP;
        end
      end
      rse_pkg::T_SWEEP: begin
        if (rd_v && rd_k == {1'b0, n_reg}) state_next = rse_pkg::T_MATH;
      end
      rse_pkg::T_MATH: begin
        if (math_done) state_next = rse_pkg::T_EMIT;
      end
      rse_pkg::T_EMIT: begin
        if (out_free) state_next = rse_pkg::T_IDLE;
      end
      default: state_next = rse_pkg::T_IDLE;
    endcase
  end

  // per-bar control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_close <= '0;
      bars_seen  <= '0;
      wp         <= '0;
      rd_v       <= 1'b0;
      math_start <= 1'b0;
    end else begin
      math_start <= 1'b0;
      if (accept) begin
        prev_close <= close_price;
        bars_seen  <= bars_next;
        if (bars_seen != '0) wp <= wp_next;
        rd_v       <= 1'b0;
      end else if (state == rse_pkg::T_SWEEP) begin
        rd_v <= (iss <= {1'b0, n_reg});
        if (rd_v && rd_k == {1'b0, n_reg}) math_start <= 1'b1;
      end
    end
  end

  // sweep the newest n+1 changes and rebuild the sums
  always_ff @(posedge clk) begin
    if (accept) begin
      raddr       <= wp_next;
      iss         <= '0;
      n_reg       <= n_new;
      s1          <= '0;
      s2          <= '0;
      p           <= '0;
      pend_valid  <= (bars_next >= rse_pkg::BARS_MIN_OUT);
      pend_spread <= '0;
    end else if (state == rse_pkg::T_SWEEP) begin
      if (iss <= {1'b0, n_reg}) begin
        raddr <= (raddr == '0) ? AW'(DEPTH - 1) : raddr - AW'(1);
        iss   <= iss + (NW+1)'(1);
        rd_k  <= iss;
      end
      if (rd_v) begin
        prevd <= rdata;
        if (rd_k != '0) begin
          s1 <= s1 + SW'(prevd);
          s2 <= s2 + SW'(rdata);
          p  <= p + PSW'(prod);
        end
      end
    end else if (state == rse_pkg::T_MATH && math_done) begin
      pend_spread <= math_spread;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == rse_pkg::T_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rse_pkg::T_EMIT && out_free) begin
      valid_res <= pend_valid;
      spread    <= pend_spread;
    end
  end

  rse_math #(
    .NW  (NW),
    .SW  (SW),
    .PSW (PSW)
  ) u_math (
    .clk    (clk),
    .rst    (rst),
    .start  (math_start),
    .n      (n_reg),
    .s1     (s1),
    .s2     (s2),
    .p      (p),
    .done   (math_done),
    .spread (math_spread)
  );

endmodule
